>>> rtl/clw_pkg.sv
// clw_pkg: shared types and constants for the character LCD writer.
// Holds request codes, byte select codes and the controller/datapath structs.
// No dependencies.
package clw_pkg;

    localparam logic [2:0] REQ_INIT  = 3'd0;
    localparam logic [2:0] REQ_CLEAR = 3'd1;
    localparam logic [2:0] REQ_GOTO  = 3'd2;
    localparam logic [2:0] REQ_CHAR  = 3'd3;
    localparam logic [2:0] REQ_HEX   = 3'd4;
    localparam logic [2:0] REQ_BIN   = 3'd5;
    localparam logic [2:0] REQ_DEC   = 3'd6;
    localparam logic [2:0] REQ_GLYPH = 3'd7;

    // byte sources for one transfer
    localparam logic [3:0] BS_02    = 4'd0;
    localparam logic [3:0] BS_28    = 4'd1;
    localparam logic [3:0] BS_38    = 4'd2;
    localparam logic [3:0] BS_0C    = 4'd3;
    localparam logic [3:0] BS_01    = 4'd4;
    localparam logic [3:0] BS_06    = 4'd5;
    localparam logic [3:0] BS_80    = 4'd6;
    localparam logic [3:0] BS_GOTO  = 4'd7;
    localparam logic [3:0] BS_LINE2 = 4'd8;
    localparam logic [3:0] BS_GADDR = 4'd9;
    localparam logic [3:0] BS_ROW   = 4'd10;
    localparam logic [3:0] BS_CHAR  = 4'd11;

    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_ZERO = 2'd1;
    localparam logic [1:0] CUR_GOTO = 2'd2;
    localparam logic [1:0] CUR_INC  = 2'd3;

    localparam int MAX_XFERS = 24;
    localparam int DAB_BITS  = 32;

    typedef struct packed {
        logic       load_req;
        logic       push;
        logic       rs;
        logic       half;
        logic [3:0] sel;
        logic [1:0] cur_op;
        logic       load_ch;
        logic       dab_step;
        logic       emit;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic       four_bit;
        logic [3:0] n_chars;
        logic       wrap_top;
        logic       wrap_mid;
        logic       slot_ok;
        logic       emit_done;
    } t_stat;

endpackage

>>> rtl/clw_req_if.sv
// clw_req_if: request channel of the character LCD writer.
// Carries valid, ready and the request fields; no dependencies.
interface clw_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         char_code;
    logic signed [31:0] number;
    logic               line_select;
    logic [3:0]         cell_req;
    logic [3:0]         glyph_slot;
    logic [63:0]        glyph_rows;

    modport source (output valid, req_type, char_code, number, line_select, cell_req,
                    glyph_slot, glyph_rows, input ready);
    modport sink   (input valid, req_type, char_code, number, line_select, cell_req,
                    glyph_slot, glyph_rows, output ready);
endinterface

>>> rtl/clw_xfer_if.sv
// clw_xfer_if: bus transfer channel of the character LCD writer.
// Carries valid, ready and one transfer; no dependencies.
interface clw_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_bits;
    logic       last_transfer;
    logic [5:0] cursor_after;

    modport source (output valid, reg_select, bus_bits, last_transfer, cursor_after,
                    input ready);
    modport sink   (input valid, reg_select, bus_bits, last_transfer, cursor_after,
                     output ready);
endinterface

>>> rtl/clw_ctrl.sv
// clw_ctrl: sequencer of the character LCD writer.
// Walks each request byte by byte and drives the datapath; uses clw_pkg.
module clw_ctrl
    import clw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [2:0] i_req_type,
    input  t_stat      i_stat,
    output logic       o_req_ready,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTES = 3'd1;
    localparam logic [2:0] S_DAB   = 3'd2;
    localparam logic [2:0] S_CHSEL = 3'd3;
    localparam logic [2:0] S_WRAP  = 3'd4;
    localparam logic [2:0] S_DATA  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_half, n_half;
    logic [2:0] r_kind, n_kind;
    logic       byte_fin;
    logic       last_byte;
    logic [3:0] script_sel;

    assign byte_fin    = !i_stat.four_bit || r_half;
    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        script_sel = BS_01;
        last_byte  = 1'b1;
        case (r_kind)
            REQ_INIT: begin
                if (i_stat.four_bit) begin
                    last_byte = (r_step == 5'd4);
                    case (r_step)
                        5'd0:    script_sel = BS_02;
                        5'd1:    script_sel = BS_28;
                        5'd2:    script_sel = BS_0C;
                        5'd3:    script_sel = BS_01;
                        default: script_sel = BS_06;
                    endcase
                end else begin
                    last_byte = (r_step == 5'd3);
                    case (r_step)
                        5'd0:    script_sel = BS_38;
                        5'd1:    script_sel = BS_0C;
                        5'd2:    script_sel = BS_01;
                        default: script_sel = BS_06;
                    endcase
                end
            end
            REQ_GOTO: script_sel = BS_GOTO;
            REQ_GLYPH: begin
                last_byte = (r_step == 5'd9);
                if (r_step == 5'd0) begin
                    script_sel = BS_GADDR;
                end else if (r_step == 5'd9) begin
                    script_sel = BS_80;
                end else begin
                    script_sel = BS_ROW;
                end
            end
            default: script_sel = BS_01;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_half  = r_half;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_kind = i_req_type;
                    n_step = '0;
                    n_half = 1'b0;
                    case (i_req_type)
                        REQ_CHAR, REQ_HEX, REQ_BIN: n_state = S_CHSEL;
                        REQ_DEC:                    n_state = S_DAB;
                        default:                    n_state = S_BYTES;
                    endcase
                end
            end
            S_BYTES: begin
                if (r_kind == REQ_GLYPH && !i_stat.slot_ok) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.half = r_half;
                    o_cmd.sel  = script_sel;
                    o_cmd.rs   = (script_sel == BS_ROW);
                    n_half     = i_stat.four_bit && !r_half;
                    if (byte_fin) begin
                        if (last_byte) begin
                            o_cmd.cur_op = (r_kind == REQ_GOTO) ? CUR_GOTO : CUR_ZERO;
                            n_state = S_EMIT;
                        end else begin
                            n_step = r_step + 5'd1;
                        end
                    end
                end
            end
            S_DAB: begin
                o_cmd.dab_step = 1'b1;
                if (r_step == 5'(DAB_BITS - 1)) begin
                    n_step  = '0;
                    n_state = S_CHSEL;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_CHSEL: begin
                o_cmd.load_ch = 1'b1;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                if (i_stat.wrap_top || i_stat.wrap_mid) begin
                    o_cmd.push = 1'b1;
                    o_cmd.half = r_half;
                    o_cmd.sel  = i_stat.wrap_top ? BS_80 : BS_LINE2;
                    n_half     = i_stat.four_bit && !r_half;
                    if (byte_fin) begin
                        o_cmd.cur_op = i_stat.wrap_top ? CUR_ZERO : CUR_HOLD;
                        n_state = S_DATA;
                    end
                end else begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.push = 1'b1;
                o_cmd.rs   = 1'b1;
                o_cmd.half = r_half;
                o_cmd.sel  = BS_CHAR;
                n_half     = i_stat.four_bit && !r_half;
                if (byte_fin) begin
                    o_cmd.cur_op = CUR_INC;
                    if (r_step + 5'd1 == {1'b0, i_stat.n_chars}) begin
                        n_state = S_EMIT;
                    end else begin
                        n_step  = r_step + 5'd1;
                        n_state = S_CHSEL;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_half  <= 1'b0;
            r_kind  <= REQ_INIT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_half  <= n_half;
            r_kind  <= n_kind;
        end
    end

endmodule

>>> rtl/clw_dp.sv
// clw_dp: datapath of the character LCD writer.
// Request capture, cursor, decimal conversion, transfer buffer and output
// register; uses clw_pkg.
module clw_dp
    import clw_pkg::*;
#(
    parameter int CELLS_PER_LINE = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_number,
    input  logic        i_line_select,
    input  logic [3:0]  i_cell_req,
    input  logic [3:0]  i_glyph_slot,
    input  logic [63:0] i_glyph_rows,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_reg_select,
    output logic [7:0]  o_bus_bits,
    output logic        o_last_transfer,
    output logic [5:0]  o_cursor_after
);

    logic        r_four;
    logic [5:0]  r_cursor;
    logic [2:0]  r_type;
    logic [7:0]  r_char;
    logic        r_neg;
    logic        r_line;
    logic [3:0]  r_cell;
    logic [3:0]  r_slot;
    logic [63:0] r_rows;
    logic [31:0] r_bin;
    logic [39:0] r_bcd;
    logic [7:0]  r_ch;
    logic [8:0]  r_buf [MAX_XFERS];
    logic [4:0]  r_cnt;
    logic [4:0]  r_idx;
    logic        r_ovalid;
    logic [8:0]  r_out;
    logic        r_olast;
    logic [5:0]  r_ocur;

    logic [7:0]  cur_byte;
    logic [7:0]  push_bits;
    logic [39:0] bcd_adj;
    logic [3:0]  nd;
    logic [3:0]  dig_idx;
    logic [3:0]  dig;
    logic [7:0]  ch_sel;
    logic [3:0]  char_cnt;
    logic [2:0]  row;
    logic [63:0] rows_sh;
    logic [6:0]  goto_pos;
    logic        out_load;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
    endfunction

    assign row      = 3'(i_cmd.step - 5'd1);
    assign rows_sh  = r_rows >> {row, 3'b000};
    assign goto_pos = (r_line ? 7'(CELLS_PER_LINE) : 7'd0) + {3'b000, r_cell};

    always_comb begin
        case (i_cmd.sel)
            BS_02:    cur_byte = 8'h02;
            BS_28:    cur_byte = 8'h28;
            BS_38:    cur_byte = 8'h38;
            BS_0C:    cur_byte = 8'h0C;
            BS_01:    cur_byte = 8'h01;
            BS_06:    cur_byte = 8'h06;
            BS_80:    cur_byte = 8'h80;
            BS_GOTO:  cur_byte = 8'h80 + (r_line ? 8'h40 : 8'h00) + {4'h0, r_cell};
            BS_LINE2: cur_byte = 8'hC0;
            BS_GADDR: cur_byte = 8'h40 + {1'b0, r_slot[2:0], 3'b000};
            BS_ROW:   cur_byte = rows_sh[7:0];
            BS_CHAR:  cur_byte = r_ch;
            default:  cur_byte = 8'h00;
        endcase
        if (!r_four) begin
            push_bits = cur_byte;
        end else if (i_cmd.half) begin
            push_bits = {4'h0, cur_byte[3:0]};
        end else begin
            push_bits = {4'h0, cur_byte[7:4]};
        end
    end

    // double-dabble adjust before each shift
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                           : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        nd = 4'd1;
        for (int i = 1; i < 10; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                nd = 4'(i + 1);
            end
        end
        dig_idx = r_neg ? (nd - i_cmd.step[3:0]) : (nd - 4'd1 - i_cmd.step[3:0]);
        dig = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (dig_idx == 4'(i)) begin
                dig = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        case (r_type)
            REQ_HEX: begin
                char_cnt = 4'd2;
                ch_sel = hex_char(i_cmd.step[0] ? r_bin[3:0] : r_bin[7:4]);
            end
            REQ_BIN: begin
                char_cnt = 4'd8;
                ch_sel = 8'h30 + {7'd0, r_bin[3'd7 - i_cmd.step[2:0]]};
            end
            REQ_DEC: begin
                char_cnt = nd + {3'd0, r_neg};
                ch_sel = (r_neg && i_cmd.step == 5'd0) ? 8'h2D : (8'h30 + {4'h0, dig});
            end
            default: begin
                char_cnt = 4'd1;
                ch_sel = r_char;
            end
        endcase
    end

    assign o_stat.n_chars   = char_cnt;
    assign o_stat.four_bit  = r_four;
    assign o_stat.wrap_top  = ({1'b0, r_cursor} >= 7'(2 * CELLS_PER_LINE));
    assign o_stat.wrap_mid  = ({1'b0, r_cursor} == 7'(CELLS_PER_LINE));
    assign o_stat.slot_ok   = !r_slot[3];
    assign o_stat.emit_done = (r_idx == r_cnt);

    assign out_load = i_cmd.emit && (r_idx != r_cnt) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four   <= 1'b1;
            r_cursor <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_four <= i_cfg_wdata;
            end
            case (i_cmd.cur_op)
                CUR_ZERO: r_cursor <= '0;
                CUR_GOTO: r_cursor <= goto_pos[5:0];
                CUR_INC:  r_cursor <= r_cursor + 6'd1;
                default:  r_cursor <= r_cursor;
            endcase
            if (i_cmd.load_req) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                if (i_cmd.push && r_cnt != 5'(MAX_XFERS)) begin
                    r_cnt <= r_cnt + 5'd1;
                end
                if (out_load) begin
                    r_idx <= r_idx + 5'd1;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type <= i_req_type;
            r_char <= i_char_code;
            r_neg  <= i_number[31];
            r_line <= i_line_select;
            r_cell <= i_cell_req;
            r_slot <= i_glyph_slot;
            r_rows <= i_glyph_rows;
            r_bcd  <= '0;
            // low byte serves hex and binary; decimal uses the magnitude
            r_bin  <= (i_req_type == REQ_DEC && i_number[31]) ? (32'd0 - i_number)
                                                              : i_number;
        end else if (i_cmd.dab_step) begin
            {r_bcd, r_bin} <= {bcd_adj[38:0], r_bin, 1'b0};
        end
        if (i_cmd.load_ch) begin
            r_ch <= ch_sel;
        end
        if (i_cmd.push && r_cnt != 5'(MAX_XFERS)) begin
            r_buf[r_cnt] <= {i_cmd.rs, push_bits};
        end
        if (out_load) begin
            r_out   <= r_buf[r_idx];
            r_olast <= (r_idx + 5'd1 == r_cnt);
            r_ocur  <= r_cursor;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_reg_select    = r_out[8];
    assign o_bus_bits      = r_out[7:0];
    assign o_last_transfer = r_olast;
    assign o_cursor_after  = r_ocur;

endmodule

>>> rtl/char_lcd_writer.sv
// char_lcd_writer: request front end for a two-line character LCD.
// Instantiates clw_ctrl and clw_dp; uses clw_pkg, clw_req_if and clw_xfer_if.
//
// Usage: i_req carries one request (init, clear, goto, char, hex, binary,
// decimal, glyph define) per transaction. o_xfer carries one LCD bus transfer
// per transaction: register select, bus bits (a nibble in bits 3..0 in 4-bit
// mode), a last flag on the final transfer of the request and the cursor as it
// stands after the whole request. i_cfg_we/i_cfg_wdata write four_bit_mode;
// the user must do so only while the block is idle; the block does not enforce it.
// A request is first expanded into an internal buffer of up to 24 transfers,
// at most one transfer per cycle, and then played out one transfer per cycle as
// the receiver takes them. Each printed character is picked, then preceded by a
// cursor move where the line wraps, then written; a decimal request first runs
// the binary to BCD shift loop over all 32 bits. An out-of-range glyph slot
// yields no transfers. The next request is taken once the sequencer returns to
// idle after the last transfer is loaded into the output register.
// Reset (synchronous, active low) selects 4-bit mode and homes the cursor.
// A stalled receiver holds the output register; the block waits for it.
module char_lcd_writer
    import clw_pkg::*;
#(
    parameter int CELLS_PER_LINE = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    clw_req_if.sink   i_req,
    clw_xfer_if.source o_xfer
);

    t_cmd  cmd;
    t_stat stat;

    clw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    clw_dp #(
        .CELLS_PER_LINE (CELLS_PER_LINE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req.req_type),
        .i_char_code     (i_req.char_code),
        .i_number        (i_req.number),
        .i_line_select   (i_req.line_select),
        .i_cell_req      (i_req.cell_req),
        .i_glyph_slot    (i_req.glyph_slot),
        .i_glyph_rows    (i_req.glyph_rows),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_xfer.valid),
        .i_ready         (o_xfer.ready),
        .o_reg_select    (o_xfer.reg_select),
        .o_bus_bits      (o_xfer.bus_bits),
        .o_last_transfer (o_xfer.last_transfer),
        .o_cursor_after  (o_xfer.cursor_after)
    );

endmodule

>>> test/tb_char_lcd_writer.sv
// tb_char_lcd_writer: checks char_lcd_writer transfers against a built-in predictor.
// Uses clw_pkg, clw_req_if, clw_xfer_if and the char_lcd_writer RTL.
`timescale 1ns / 1ps
module tb_char_lcd_writer;
    import clw_pkg::*;

    localparam int CELLS = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic       rs;
        logic [7:0] bits;
        logic       last;
        logic [5:0] cursor;
    } t_xfer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b1;

    clw_req_if  req_ch();
    clw_xfer_if xfer_ch();

    char_lcd_writer #(.CELLS_PER_LINE(CELLS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch.sink),
        .o_xfer     (xfer_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic       nibble_mode;
    logic [5:0] pred_pos;
    t_xfer      pending[$];
    t_xfer      req_xfers[$];
    int         errors;
    int         stall_pct;
    int         idle_cycles;
    bit         timed_out;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INIT;
        req_ch.char_code = '0;
        req_ch.number = '0;
        req_ch.line_select = 1'b0;
        req_ch.cell_req = '0;
        req_ch.glyph_slot = '0;
        req_ch.glyph_rows = '0;
        xfer_ch.ready = 1'b0;
    end

    function automatic void add_xfer(input logic rs, input logic [7:0] b);
        t_xfer x;
        x.rs = rs;
        x.bits = b;
        x.last = 1'b0;
        x.cursor = '0;
        if (req_xfers.size() < MAX_XFERS) req_xfers.push_back(x);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] b);
        if (nibble_mode) begin
            add_xfer(rs, {4'h0, b[7:4]});
            add_xfer(rs, {4'h0, b[3:0]});
        end else begin
            add_xfer(rs, b);
        end
    endfunction

    function automatic void move_cursor(input logic line, input logic [3:0] col);
        add_byte(1'b0, 8'h80 + (line ? 8'h40 : 8'h00) + col);
        pred_pos = 6'((line ? CELLS : 0) + col);
    endfunction

    function automatic void print_char(input logic [7:0] ch);
        if (pred_pos >= 2 * CELLS) move_cursor(1'b0, 4'd0);
        else if (pred_pos == CELLS) move_cursor(1'b1, 4'd0);
        add_byte(1'b1, ch);
        pred_pos = pred_pos + 6'd1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 10) ? 8'h30 + v : 8'h41 + (v - 10);
    endfunction

    function automatic void predict_request(input logic [2:0] kind, input logic [7:0] ch,
                                            input logic [31:0] num, input logic line,
                                            input logic [3:0] col, input logic [3:0] slot,
                                            input logic [63:0] rows);
        logic [31:0] mag;
        logic [7:0]  digits[10];
        int          n;
        req_xfers.delete();
        case (kind)
            REQ_INIT: begin
                if (nibble_mode) begin
                    add_byte(1'b0, 8'h02);
                    add_byte(1'b0, 8'h28);
                end else begin
                    add_byte(1'b0, 8'h38);
                end
                add_byte(1'b0, 8'h0C);
                add_byte(1'b0, 8'h01);
                add_byte(1'b0, 8'h06);
                pred_pos = '0;
            end
            REQ_CLEAR: begin
                add_byte(1'b0, 8'h01);
                pred_pos = '0;
            end
            REQ_GOTO: move_cursor(line, col);
            REQ_CHAR: print_char(ch);
            REQ_HEX: begin
                print_char(hex_char(num[7:4]));
                print_char(hex_char(num[3:0]));
            end
            REQ_BIN: begin
                for (int i = 7; i >= 0; i--) print_char(num[i] ? 8'h31 : 8'h30);
            end
            REQ_DEC: begin
                mag = num;
                if (num[31]) begin
                    print_char(8'h2D);
                    mag = -num;
                end
                if (mag == 0) begin
                    print_char(8'h30);
                end else begin
                    n = 0;
                    while (mag != 0) begin
                        digits[n] = 8'h30 + 8'(mag % 10);
                        mag = mag / 10;
                        n++;
                    end
                    while (n > 0) begin
                        n--;
                        print_char(digits[n]);
                    end
                end
            end
            default: begin
                if (slot < 8) begin
                    add_byte(1'b0, 8'h40 + {1'b0, slot[2:0], 3'b000});
                    for (int i = 0; i < 8; i++) add_byte(1'b1, rows[8*i +: 8]);
                    add_byte(1'b0, 8'h80);
                    pred_pos = '0;
                end
            end
        endcase
        for (int i = 0; i < req_xfers.size(); i++) begin
            req_xfers[i].last = (i == req_xfers.size() - 1);
            req_xfers[i].cursor = pred_pos;
            pending.push_back(req_xfers[i]);
        end
    endfunction

    // receiver with random stalls, checks each transaction
    always @(posedge i_clk) begin
        t_xfer got;
        t_xfer want;
        if (i_rst_n) begin
            if (xfer_ch.valid && xfer_ch.ready) begin
                got = '{xfer_ch.reg_select, xfer_ch.bus_bits, xfer_ch.last_transfer,
                        xfer_ch.cursor_after};
                if (pending.size() == 0) begin
                    $display("%0t: unexpected transfer %h", $time, got);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    if (got.rs !== want.rs) begin
                        $display("%0t: reg_select exp %b got %b", $time, want.rs, got.rs);
                        errors++;
                    end
                    if (got.bits !== want.bits) begin
                        $display("%0t: bus_bits exp %h got %h", $time, want.bits, got.bits);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_transfer exp %b got %b", $time, want.last,
                                 got.last);
                        errors++;
                    end
                    if (got.cursor !== want.cursor) begin
                        $display("%0t: cursor_after exp %0d got %0d", $time, want.cursor,
                                 got.cursor);
                        errors++;
                    end
                end
            end
        end
        xfer_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (xfer_ch.valid && xfer_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(input logic [2:0] kind, input logic [7:0] ch,
                                input logic [31:0] num, input logic line,
                                input logic [3:0] col, input logic [3:0] slot,
                                input logic [63:0] rows);
        while ($urandom_range(99) < stall_pct) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.char_code <= ch;
        req_ch.number <= num;
        req_ch.line_select <= line;
        req_ch.cell_req <= col;
        req_ch.glyph_slot <= slot;
        req_ch.glyph_rows <= rows;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        predict_request(kind, ch, num, line, col, slot, rows);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic nibbles);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= nibbles;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        nibble_mode = nibbles;
    endtask

    task automatic send_random;
        logic [2:0]  kind;
        logic [31:0] num;
        int          pick;
        kind = 3'($urandom_range(7));
        num = $urandom;
        pick = $urandom_range(9);
        if (pick == 0) num = 32'h8000_0000;
        else if (pick == 1) num = 32'h7FFF_FFFF;
        else if (pick < 5) num = 32'($signed(-1000 + $urandom_range(2000)));
        send_request(kind, 8'($urandom), num, 1'($urandom), 4'($urandom),
                     4'($urandom), {$urandom, $urandom});
    endtask

    task automatic test_directed;
        send_request(REQ_INIT, 8'h00, 0, 0, 0, 0, 0);
        send_request(REQ_CLEAR, 8'h00, 0, 0, 0, 0, 0);
        send_request(REQ_GOTO, 8'h00, 0, 1'b1, 4'hF, 0, 0);
        send_request(REQ_CHAR, 8'hFF, 0, 0, 0, 0, 0);
        send_request(REQ_GOTO, 8'h00, 0, 1'b0, 4'hF, 0, 0);
        // cross from line one into line two
        send_request(REQ_CHAR, 8'h41, 0, 0, 0, 0, 0);
        send_request(REQ_CHAR, 8'h00, 0, 0, 0, 0, 0);
        send_request(REQ_HEX, 8'h00, 32'h0000_00A5, 0, 0, 0, 0);
        send_request(REQ_HEX, 8'h00, 32'hFFFF_FF0F, 0, 0, 0, 0);
        send_request(REQ_BIN, 8'h00, 32'h0000_005A, 0, 0, 0, 0);
        send_request(REQ_DEC, 8'h00, 32'h0000_0000, 0, 0, 0, 0);
        send_request(REQ_DEC, 8'h00, 32'h8000_0000, 0, 0, 0, 0);
        send_request(REQ_DEC, 8'h00, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_request(REQ_DEC, 8'h00, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_request(REQ_GLYPH, 8'h00, 0, 0, 0, 4'd7, 64'hFFFF_0000_AAAA_5555);
        send_request(REQ_GLYPH, 8'h00, 0, 0, 0, 4'd0, 64'h0123_4567_89AB_CDEF);
        // slot out of range: nothing comes out
        send_request(REQ_GLYPH, 8'h00, 0, 0, 0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(REQ_GLYPH, 8'h00, 0, 0, 0, 4'd15, 0);
        send_request(REQ_GOTO, 8'h00, 0, 1'b1, 4'hF, 0, 0);
        // wrap from end of line two back to line one
        send_request(REQ_BIN, 8'h00, 32'h0000_00FF, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_random();
    endtask

    initial begin
        errors = 0;
        timed_out = 0;
        stall_pct = 15;
        idle_cycles = 0;
        nibble_mode = 1'b1;
        pred_pos = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_mode(1'b0);
        test_directed();
        test_random(130);
        stall_pct = 0;
        test_random(70);
        stall_pct = 15;
        set_mode(1'b1);
        test_random(200);
        drain();
        if (errors == 0 && !timed_out) begin
            $display("** char_lcd_writer: PASSED **");
        end else begin
            $display("** char_lcd_writer: FAILED **");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1;
        $display("** char_lcd_writer: FAILED **");
        $finish;
    end
endmodule
